/* rtl/core/fia_pkg.sv */
// Package with shared types, codes and constants of the folding integer ALU.
`timescale 1ns / 1ps
package fia_pkg;

	localparam int unsigned DataW = 64;
	localparam int unsigned CntW  = 7;

	typedef logic [DataW-1:0] data_t;

	// Operation codes as carried in func.
	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MOD = 3'd4,
		OP_POW = 3'd5,
		OP_MAX = 3'd6,
		OP_MIN = 3'd7
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DIV0   = 2'd1,
		ST_UNARY  = 2'd2,
		ST_UNUSED = 2'd3
	} status_t;

	// Sequencer states of the shared unit.
	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_POW_SQ,
		S_POW_ML,
		S_DONE
	} state_t;

	// Command from the control to the iterative unit.
	typedef struct packed {
		logic  start;
		op_t   op;
		data_t a;
		data_t b;
	} unit_cmd_t;

	// Response of the iterative unit.
	typedef struct packed {
		logic  done;
		logic  div0;
		data_t res;
	} unit_rsp_t;

endpackage

/* rtl/core/fia_if.sv */
// Valid/ready channel interfaces for the input and result items.
`timescale 1ns / 1ps
interface fia_in_if import fia_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [2:0] func;
	data_t      operand;
	logic       first;
	logic       last_operand;
	modport source (output valid, func, operand, first, last_operand, input ready);
	modport sink (input valid, func, operand, first, last_operand, output ready);
endinterface

interface fia_out_if import fia_pkg::*; ();
	logic       valid;
	logic       ready;
	data_t      value;
	logic [1:0] status;
	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

/* rtl/core/fia_unit.sv */
// Shared iterative unit: one adder/subtractor step per cycle for multiply, divide and power.
`timescale 1ns / 1ps
module fia_unit import fia_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  unit_cmd_t cmd,
	output unit_rsp_t rsp
);

	state_t      state_q, state_d;
	logic [CntW-1:0] cnt_q;
	op_t         op_q;
	data_t       acc_q;   // product or quotient being built
	data_t       aux_q;   // multiplicand or remainder
	data_t       ex_q;    // multiplier bits / dividend bits / exponent
	data_t       base_q;  // power base or divisor magnitude
	data_t       res_q;   // power running result
	data_t       pm_q;    // remaining exponent bits for power steps
	logic        neg_q, rneg_q, pmode_q;
	logic        done_q, div0_q;

	// Datapath: a 64-bit add for multiply and a separate 65-bit subtract for divide.
	logic [DataW:0] trial;
	data_t          rem_sh;
	data_t          mag_a, mag_b;
	always_comb begin
		rem_sh = {aux_q[DataW-2:0], ex_q[DataW-1]};
		trial  = {1'b0, rem_sh} - {1'b0, base_q};
		mag_a  = cmd.a[DataW-1] ? (~cmd.a + 1'b1) : cmd.a;
		mag_b  = cmd.b[DataW-1] ? (~cmd.b + 1'b1) : cmd.b;
	end

	// Next state. A power result pass is followed by a square pass while exponent bits
	// remain, and a square pass is always followed by a result pass.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.start) begin
					case (cmd.op)
						OP_MUL: state_d = S_MUL;
						OP_DIV, OP_MOD: state_d = (cmd.b == '0) ? S_DONE : S_DIV;
						OP_POW: state_d = (cmd.b[DataW-1] || cmd.b == '0) ? S_DONE : S_POW_ML;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_MUL: begin
				if (cnt_q == CntW'(DataW - 1)) begin
					if (!pmode_q) state_d = S_DONE;
					else if (neg_q) state_d = S_POW_ML;
					else if (pm_q[DataW-1:1] == '0) state_d = S_DONE;
					else state_d = S_POW_SQ;
				end
			end
			S_DIV: if (cnt_q == CntW'(DataW - 1)) state_d = S_DONE;
			S_POW_ML: state_d = S_MUL;
			S_POW_SQ: state_d = S_MUL;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_d == S_DONE) && (state_q != S_DONE);
		end
	end

	// Datapath registers. Power runs as alternate multiply passes: result*=base
	// when the exponent bit is set, then base*=base, one shift-add pass each.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd.start) begin
					op_q    <= cmd.op;
					cnt_q   <= '0;
					pmode_q <= (cmd.op == OP_POW);
					div0_q  <= ((cmd.op inside {OP_DIV, OP_MOD}) && cmd.b == '0) ||
						(cmd.op == OP_POW && cmd.a == '0 && cmd.b[DataW-1]);
					case (cmd.op)
						OP_MUL: begin
							acc_q <= '0;
							aux_q <= cmd.a;
							ex_q  <= cmd.b;
						end
						OP_DIV, OP_MOD: begin
							acc_q  <= '0;
							aux_q  <= '0;
							ex_q   <= mag_a;
							base_q <= mag_b;
							neg_q  <= cmd.a[DataW-1] ^ cmd.b[DataW-1];
							rneg_q <= cmd.a[DataW-1];
						end
						OP_POW: begin
							base_q  <= cmd.a;
							pm_q    <= cmd.b;
							ex_q    <= cmd.b;
							neg_q   <= 1'b0;
							// A negative exponent is settled here from the base and the exponent's parity.
							if (!cmd.b[DataW-1] || cmd.a == DataW'(1)) res_q <= DataW'(1);
							else if (cmd.a == '1) res_q <= cmd.b[0] ? cmd.a : DataW'(1);
							else res_q <= '0;
						end
						default: ;
					endcase
				end
			end
			S_POW_ML: begin
				// result * base when the low exponent bit is set, else result * 1
				acc_q  <= '0;
				aux_q  <= res_q;
				ex_q   <= pm_q[0] ? base_q : DataW'(1);
				neg_q  <= 1'b0;
				cnt_q  <= '0;
			end
			S_POW_SQ: begin
				acc_q <= '0;
				aux_q <= base_q;
				ex_q  <= base_q;
				neg_q <= 1'b1;
				cnt_q <= '0;
			end
			S_MUL: begin
				acc_q <= acc_q + (ex_q[0] ? aux_q : '0);
				aux_q <= {aux_q[DataW-2:0], 1'b0};
				ex_q  <= {1'b0, ex_q[DataW-1:1]};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DataW - 1) && pmode_q) begin
					if (!neg_q) begin
						res_q <= acc_q + (ex_q[0] ? aux_q : '0);
						pm_q  <= {1'b0, pm_q[DataW-1:1]};
					end else begin
						base_q <= acc_q + (ex_q[0] ? aux_q : '0);
					end
				end
			end
			S_DIV: begin
				ex_q  <= {ex_q[DataW-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (!trial[DataW]) begin
					aux_q <= trial[DataW-1:0];
					acc_q <= {acc_q[DataW-2:0], 1'b1};
				end else begin
					aux_q <= rem_sh;
					acc_q <= {acc_q[DataW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		rsp.done = done_q;
		rsp.div0 = div0_q;
		case (op_q)
			OP_DIV:  rsp.res = neg_q ? (~acc_q + 1'b1) : acc_q;
			OP_MOD:  rsp.res = rneg_q ? (~aux_q + 1'b1) : aux_q;
			OP_POW:  rsp.res = res_q;
			default: rsp.res = acc_q;
		endcase
	end

	// Done is a single-cycle pulse.
	assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("unit done held for two cycles");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q < CntW'(DataW)))
		else $error("divide step count overran");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> (state_q == S_IDLE))
		else $error("unit did not return to idle");

endmodule

/* rtl/core/folding_integer_alu_core.sv */
// Top level of the folding integer ALU: item control, accumulator and result register.
//
// Channel | Dir | Payload                            | Accept
// in      | in  | func, operand, first, last_operand | valid && ready
// res     | out | value, status                      | valid && ready
//
// Add, subtract, max, min, loads and operands skipped after an error need no pass of the unit.
// Multiply, divide and modulo hold the input while the unit works (one bit per cycle).
// Power holds it for a result pass per significant exponent bit with a square pass between;
// a zero or negative exponent and division by zero go straight to the unit's done state.
// A result is flagged by emit_q, then offered from a register; while it waits only a
// last item is held back. arst_n clears the accumulator, held operation and error code.
`timescale 1ns / 1ps
module folding_integer_alu_core import fia_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	fia_in_if.sink      in,
	fia_out_if.source   res
);

	data_t      acc_q;
	op_t        hop_q;
	logic [1:0] err_q;
	logic       busy_q, last_q;
	logic       emit_q;
	logic       ovalid_q;
	data_t      oval_q;
	logic [1:0] ost_q;
	unit_cmd_t  cmd;
	unit_rsp_t  rsp;
	logic       acc_in;
	logic       need_unit;
	op_t        in_op;

	assign in_op    = op_t'(in.func);
	assign in.ready = !busy_q && !((ovalid_q || emit_q) && in.last_operand);
	assign acc_in   = in.valid && in.ready;
	assign need_unit = !in.first && (err_q == ST_OK) &&
		(hop_q inside {OP_MUL, OP_DIV, OP_MOD, OP_POW});

	// Command to the shared unit.
	always_comb begin
		cmd.start = acc_in && need_unit;
		cmd.op    = hop_q;
		cmd.a     = acc_q;
		cmd.b     = in.operand;
	end

	fia_unit u_unit (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	// Item handling, the accumulator and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			hop_q    <= OP_ADD;
			err_q    <= '0;
			busy_q   <= 1'b0;
			last_q   <= 1'b0;
			emit_q   <= 1'b0;
			ovalid_q <= 1'b0;
			oval_q   <= '0;
			ost_q    <= '0;
		end else begin
			busy_q   <= busy_q ? !rsp.done : (acc_in && need_unit);
			emit_q   <= (acc_in && !need_unit && in.last_operand) ||
				(busy_q && rsp.done && last_q);
			ovalid_q <= emit_q || (ovalid_q && !res.ready);
			if (emit_q) begin
				oval_q <= (err_q != ST_OK) ? '0 : acc_q;
				ost_q  <= err_q;
			end
			if (busy_q) begin
				if (rsp.done) begin
					if (rsp.div0) err_q <= ST_DIV0;
					else acc_q <= rsp.res;
				end
			end else if (acc_in) begin
				last_q <= in.last_operand;
				if (in.first) begin
					hop_q <= in_op;
					if (in.last_operand && in_op == OP_SUB) acc_q <= '0 - in.operand;
					else acc_q <= in.operand;
					if (in.last_operand && in_op != OP_SUB) err_q <= ST_UNARY;
					else err_q <= ST_OK;
				end else if (err_q == ST_OK) begin
					case (hop_q)
						OP_ADD: acc_q <= acc_q + in.operand;
						OP_SUB: acc_q <= acc_q - in.operand;
						OP_MAX: if ($signed(acc_q) < $signed(in.operand)) acc_q <= in.operand;
						OP_MIN: if ($signed(in.operand) < $signed(acc_q)) acc_q <= in.operand;
						default: ;
					endcase
				end
			end
		end
	end

	assign res.valid  = ovalid_q;
	assign res.status = ost_q;
	assign res.value  = oval_q;

	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> !in.ready)
		else $error("input ready while unit busy");
	assert property (@(posedge clk) disable iff (!arst_n) emit_q |-> !ovalid_q)
		else $error("result register overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(res.value) && $stable(res.status)))
		else $error("result dropped or changed while waiting");

endmodule
